>>> sv/lcdns_pkg.sv
// Shared types, constants and helpers for the character LCD nibble sequencer.
// No dependencies; every other file but lcdns_if imports this package.
package lcdns_pkg;

    localparam int COLUMNS  = 16;
    localparam int QDEPTH   = 2;
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int APB_AW   = 5;
    localparam int STEP_W   = 5;

    localparam logic [7:0] CMD_CLEAR = 8'h01;
    localparam logic [7:0] CMD_HOME  = 8'h80;
    localparam logic [7:0] CMD_ROW0  = 8'h80;
    localparam logic [7:0] CMD_ROW1  = 8'hC0;

    localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 5'd3;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 5'd25;
    localparam logic [STEP_W-1:0] CLEAR_WAIT_STEP = 5'd4;
    localparam logic [STEP_W-1:0] CLEAR_HOME_STEP = 5'd5;
    localparam logic [STEP_W-1:0] CLEAR_LAST_STEP = 5'd8;

    typedef enum logic [2:0] {
        FN_CMD    = 3'd0,
        FN_CHAR   = 3'd1,
        FN_CURSOR = 3'd2,
        FN_INIT   = 3'd3,
        FN_CLEAR  = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        REG_STROBE     = 3'd0,
        REG_CHAR_LOW   = 3'd1,
        REG_SETTLE     = 3'd2,
        REG_POWER_WAIT = 3'd3,
        REG_CLEAR_WAIT = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        JK_BYTE  = 2'd0,
        JK_INIT  = 2'd1,
        JK_CLEAR = 2'd2
    } t_job_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_seq_state;

    typedef struct packed {
        t_job_kind  kind;
        logic       rs;
        logic       char_low;
        logic [7:0] data;
    } t_job;

    typedef struct packed {
        logic [9:0]  strobe_us;
        logic [9:0]  char_low_strobe_us;
        logic [13:0] settle_us;
        logic [15:0] power_wait_us;
        logic [15:0] clear_wait_us;
    } t_cfg;

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] cmd;
        case (idx)
            3'd0:    cmd = 8'h33;
            3'd1:    cmd = 8'h32;
            3'd2:    cmd = 8'h28;
            3'd3:    cmd = 8'h0F;
            3'd4:    cmd = 8'h06;
            3'd5:    cmd = 8'h01;
            default: cmd = 8'h00;
        endcase
        return cmd;
    endfunction

endpackage

>>> sv/lcdns_if.sv
// Valid/ready channel interfaces for requests and pin phases.
// Standalone; payload widths follow the request and phase fields.
interface lcdns_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] value;
    logic [7:0] column;
    logic [7:0] row;

    modport source(output valid, func, value, column, row, input ready);
    modport sink(input valid, func, value, column, row, output ready);
endinterface

interface lcdns_phase_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic [3:0]  nibble;
    logic        enable;
    logic [15:0] hold_us;
    logic        last;

    modport source(output valid, reg_select, nibble, enable, hold_us, last, input ready);
    modport sink(input valid, reg_select, nibble, enable, hold_us, last, output ready);
endinterface

>>> sv/char_lcd_nibble_sequencer.sv
// Character LCD nibble sequencer, top level: timing registers, front end, queue, sequencer.
// A transfer is written into the job queue, popped into the sequencer when it is idle, and
// each phase is registered in the output slot; one phase per cycle while the sink takes
// them. A request occupies the sequencer from its pop until its last phase is emitted.
// Synchronous active-low reset: timing registers return to defaults, held RS and D7..D4
// return to zero, the job queue empties. Depends on lcdns_pkg and lcdns_if.
module char_lcd_nibble_sequencer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lcdns_req_if.sink                    i_req,
    lcdns_phase_if.source                o_phase,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lcdns_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import lcdns_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    t_job front_job;
    t_job queue_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // Register file: one word per timing register, written on the access phase.
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.strobe_us          <= 10'd10;
            r_cfg.char_low_strobe_us <= 10'd1;
            r_cfg.settle_us          <= 14'd200;
            r_cfg.power_wait_us      <= 16'd20000;
            r_cfg.clear_wait_us      <= 16'd2000;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_STROBE:     r_cfg.strobe_us          <= pwdata[9:0];
                REG_CHAR_LOW:   r_cfg.char_low_strobe_us <= pwdata[9:0];
                REG_SETTLE:     r_cfg.settle_us          <= pwdata[13:0];
                REG_POWER_WAIT: r_cfg.power_wait_us      <= pwdata[15:0];
                REG_CLEAR_WAIT: r_cfg.clear_wait_us      <= pwdata[15:0];
                default: begin
                    // hold: addresses past the list are ignored
                end
            endcase
        end
    end

    // Read back; unmapped addresses return zero.
    always_comb begin
        case (reg_idx)
            REG_STROBE:     prdata = {22'd0, r_cfg.strobe_us};
            REG_CHAR_LOW:   prdata = {22'd0, r_cfg.char_low_strobe_us};
            REG_SETTLE:     prdata = {18'd0, r_cfg.settle_us};
            REG_POWER_WAIT: prdata = {16'd0, r_cfg.power_wait_us};
            REG_CLEAR_WAIT: prdata = {16'd0, r_cfg.clear_wait_us};
            default:        prdata = 32'd0;
        endcase
    end

    // Front end: classify each transfer, drop unknown and off-panel requests, push jobs.
    lcdns_front u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_job  (front_job)
    );

    // Decouple intake from phase generation so either side can stall.
    lcdns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (queue_job),
        .o_full  (full),
        .o_empty (empty)
    );

    // Back end: step through each job's phases into a registered output slot.
    lcdns_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (queue_job),
        .i_job_valid (!empty),
        .o_pop       (pop),
        .o_phase     (o_phase)
    );

endmodule

>>> sv/lcdns_front.sv
// Request front end: accepts requests, drops unknown functions and off-panel cursor moves, turns the rest into jobs.
// Depends on lcdns_pkg and lcdns_req_if.
module lcdns_front (
    lcdns_req_if.sink       i_req,
    input  logic            i_full,
    output logic            o_push,
    output lcdns_pkg::t_job o_job
);
    import lcdns_pkg::*;

    logic keep;

    assign i_req.ready = !i_full;

    always_comb begin
        keep          = 1'b1;
        o_job.kind    = JK_BYTE;
        o_job.rs      = 1'b0;
        o_job.char_low = 1'b0;
        o_job.data    = i_req.value;
        case (i_req.func)
            FN_CMD: begin
            end
            FN_CHAR: begin
                o_job.rs       = 1'b1;
                o_job.char_low = 1'b1;
            end
            FN_CURSOR: begin
                // drop moves outside the panel
                keep       = ({1'b0, i_req.column} < 9'(COLUMNS)) && (i_req.row <= 8'd1);
                o_job.data = ((i_req.row == 8'd0) ? CMD_ROW0 : CMD_ROW1)
                             | {4'h0, i_req.column[3:0]};
            end
            FN_INIT: begin
                o_job.kind = JK_INIT;
            end
            FN_CLEAR: begin
                o_job.kind = JK_CLEAR;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = i_req.valid && !i_full && keep;

endmodule

>>> sv/lcdns_queue.sv
// Short job queue between the front end and the phase sequencer.
// Depends on lcdns_pkg.
module lcdns_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lcdns_pkg::t_job i_job,
    input  logic            i_pop,
    output lcdns_pkg::t_job o_job,
    output logic            o_full,
    output logic            o_empty
);
    import lcdns_pkg::*;

    t_job                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCOUNT_W-1:0] r_count;

    assign o_full  = (r_count == QCOUNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full job queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("pop from empty job queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCOUNT_W'(QDEPTH)) else $error("job queue count overflow");

endmodule

>>> sv/lcdns_back.sv
// Phase sequencer: walks one job at a time through its pin phases.
// Depends on lcdns_pkg and lcdns_phase_if.
module lcdns_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lcdns_pkg::t_cfg i_cfg,
    input  lcdns_pkg::t_job i_job,
    input  logic            i_job_valid,
    output logic            o_pop,
    lcdns_phase_if.source   o_phase
);
    import lcdns_pkg::*;

    t_seq_state        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    t_job              r_job;
    logic              r_held_rs;
    logic [3:0]        r_held_nib;

    logic        r_out_valid;
    logic        r_out_rs;
    logic [3:0]  r_out_nib;
    logic        r_out_en;
    logic [15:0] r_out_hold;
    logic        r_out_last;

    logic              emit;
    logic              ph_wait;
    logic [15:0]       ph_wait_us;
    logic [7:0]        ph_data;
    logic [1:0]        ph_sub;
    logic              ph_last;
    logic [STEP_W-1:0] step_m1;
    logic [STEP_W-1:0] step_m5;
    logic              ph_rs;
    logic [3:0]        ph_nib;
    logic              ph_en;
    logic [15:0]       ph_hold;

    assign step_m1 = r_step - 5'd1;
    assign step_m5 = r_step - CLEAR_HOME_STEP;

    // decode the current step into a byte and a sub-phase, or a wait
    always_comb begin
        ph_wait    = 1'b0;
        ph_wait_us = i_cfg.power_wait_us;
        ph_data    = r_job.data;
        ph_sub     = r_step[1:0];
        ph_last    = 1'b0;
        case (r_job.kind)
            JK_BYTE: begin
                ph_last = (r_step == BYTE_LAST_STEP);
            end
            JK_INIT: begin
                ph_wait = (r_step == '0) || (r_step == INIT_LAST_STEP);
                ph_data = init_cmd(step_m1[4:2]);
                ph_sub  = step_m1[1:0];
                ph_last = (r_step == INIT_LAST_STEP);
            end
            JK_CLEAR: begin
                ph_wait_us = i_cfg.clear_wait_us;
                ph_wait    = (r_step == CLEAR_WAIT_STEP);
                if (r_step < CLEAR_WAIT_STEP) begin
                    ph_data = CMD_CLEAR;
                end else begin
                    ph_data = CMD_HOME;
                    ph_sub  = step_m5[1:0];
                end
                ph_last = (r_step == CLEAR_LAST_STEP);
            end
            default: begin
                ph_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        if (ph_wait) begin
            ph_rs   = r_held_rs;
            ph_nib  = r_held_nib;
            ph_en   = 1'b0;
            ph_hold = ph_wait_us;
        end else begin
            ph_rs  = r_job.rs;
            ph_nib = ph_sub[1] ? ph_data[3:0] : ph_data[7:4];
            ph_en  = !ph_sub[0];
            if (ph_sub[0]) begin
                ph_hold = {2'b00, i_cfg.settle_us};
            end else if (ph_sub[1] && r_job.char_low) begin
                ph_hold = {6'd0, i_cfg.char_low_strobe_us};
            end else begin
                ph_hold = {6'd0, i_cfg.strobe_us};
            end
        end
    end

    assign emit = (r_state == ST_RUN) && (!r_out_valid || o_phase.ready);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                if (emit) begin
                    if (ph_last) begin
                        n_state = ST_IDLE;
                        n_step  = '0;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_step  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_held_rs   <= 1'b0;
            r_held_nib  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (emit) begin
                r_out_valid <= 1'b1;
                r_held_rs   <= ph_rs;
                r_held_nib  <= ph_nib;
            end else if (o_phase.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (emit) begin
            r_out_rs   <= ph_rs;
            r_out_nib  <= ph_nib;
            r_out_en   <= ph_en;
            r_out_hold <= ph_hold;
            r_out_last <= ph_last;
        end
    end

    assign o_phase.valid      = r_out_valid;
    assign o_phase.reg_select = r_out_rs;
    assign o_phase.nibble     = r_out_nib;
    assign o_phase.enable     = r_out_en;
    assign o_phase.hold_us    = r_out_hold;
    assign o_phase.last       = r_out_last;

    a_idle_step_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_step == '0)) else $error("step not cleared in idle");
    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && ph_last) |=> (r_state == ST_IDLE)) else $error("job ran past last phase");
    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE && i_job_valid)) else $error("pop while busy");

endmodule
